/* design/frx_pkg.sv */
// ----------------------------------------------------------------------------
// frx_pkg
// Types and constants shared by the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package frx_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned VERDICT_W    = 3;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam int unsigned HEADER_BYTES   = 4;
  localparam int unsigned OVERHEAD_BYTES = 5;

  localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET = 8'h00;
  localparam logic [BYTE_W-1:0] MIN_TYPE_RESET  = 8'h10;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_TYPE  = 1'd1;

  localparam logic [VERDICT_W-1:0] VERDICT_NONE     = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT   = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BADSUM   = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_FILTERED = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    byte_out;
    logic                 in_frame;
    logic [BYTE_W-1:0]    position;
    logic [BYTE_W-1:0]    frame_type;
    logic [VERDICT_W-1:0] verdict;
    logic                 frame_last;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] min_frame_type;
  } cfg_t;

endpackage

`default_nettype wire

/* design/frx_stream_if.sv */
// ----------------------------------------------------------------------------
// frx_stream_if
// Valid/ready channel carrying one item payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface frx_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* design/frx_parser.sv */
// ----------------------------------------------------------------------------
// frx_parser
// Frame state and per-byte framing logic: sync hunt, header capture,
// running XOR, end-of-frame verdict and overflow drop.
// ----------------------------------------------------------------------------
`default_nettype none

module frx_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire frx_pkg::cfg_t     cfg,
  input  wire logic              advance,
  input  wire logic [7:0]        rx_byte,
  output frx_pkg::result_t       result
);
  import frx_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CMP_W = 32;

  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  byte_count_next;
  logic [LEN_W-1:0]  declared_length;
  logic [LEN_W-1:0]  declared_length_next;
  logic [BYTE_W-1:0] current_type;
  logic [BYTE_W-1:0] current_type_next;
  logic [BYTE_W-1:0] running_xor;
  logic [BYTE_W-1:0] running_xor_next;

  logic [CNT_W-1:0]  count_inc;
  logic              frame_end;

  always_comb begin
    count_inc            = byte_count + CNT_W'(1);
    byte_count_next      = byte_count;
    declared_length_next = declared_length;
    current_type_next    = current_type;
    running_xor_next     = running_xor;
    frame_end            = 1'b0;

    result.byte_out   = rx_byte;
    result.in_frame   = 1'b0;
    result.position   = '0;
    result.frame_type = '0;
    result.verdict    = VERDICT_NONE;
    result.frame_last = 1'b0;

    if (byte_count == '0) begin
      if (rx_byte == cfg.sync_byte) begin
        byte_count_next      = CNT_W'(1);
        running_xor_next     = rx_byte;
        declared_length_next = '0;
        current_type_next    = '0;
        result.in_frame      = 1'b1;
      end
    end else begin
      result.in_frame = 1'b1;
      result.position = BYTE_W'(byte_count);
      if (byte_count == CNT_W'(1)) begin
        current_type_next = rx_byte;
      end else if (byte_count == CNT_W'(2)) begin
        declared_length_next = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
      end else if (byte_count == CNT_W'(3)) begin
        declared_length_next = {rx_byte, declared_length[BYTE_W-1:0]};
      end
      result.frame_type = current_type_next;
      byte_count_next   = count_inc;

      frame_end = (CMP_W'(count_inc) >= CMP_W'(HEADER_BYTES)) &&
                  (CMP_W'(count_inc) >=
                   CMP_W'(declared_length_next) + CMP_W'(OVERHEAD_BYTES));

      if (frame_end) begin
        if (running_xor != rx_byte) begin
          result.verdict = VERDICT_BADSUM;
        end else if (current_type_next >= cfg.min_frame_type) begin
          result.verdict = VERDICT_ACCEPT;
        end else begin
          result.verdict = VERDICT_FILTERED;
        end
        result.frame_last = 1'b1;
        byte_count_next   = '0;
      end else begin
        running_xor_next = running_xor ^ rx_byte;
        if (CMP_W'(count_inc) >= CMP_W'(MAX_FRAME_BYTES)) begin
          result.verdict    = VERDICT_OVERFLOW;
          result.frame_last = 1'b1;
          byte_count_next   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      declared_length <= '0;
      current_type    <= '0;
      running_xor     <= '0;
    end else if (advance) begin
      byte_count      <= byte_count_next;
      declared_length <= declared_length_next;
      current_type    <= current_type_next;
      running_xor     <= running_xor_next;
    end
  end

endmodule

`default_nettype wire

/* design/sync_length_xor_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// Byte-stream frame receiver with sync hunt, length field and XOR checksum.
// ----------------------------------------------------------------------------
// One received byte per item in, one result item per byte out. Each byte is
// held in an input register, framed by single-pass logic against the frame
// state, and the result lands in an output register; a new byte is taken in
// every cycle while the output side keeps up, so throughput is one item per
// clock. Frames are sync, type, 16-bit little-endian length, payload, XOR
// checksum of all earlier bytes. The verdict comes on the checksum byte, or
// overflow drop when a frame reaches MAX_FRAME_BYTES without ending.
// Registers: index 0 sync byte (reset 0x00), index 1 minimum accepted type
// (reset 0x10); write them only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_xor_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [frx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [frx_pkg::CFG_DATA_W-1:0]  cfg_data,
  frx_stream_if.sink                         byte_in,
  frx_stream_if.source                       result
);
  import frx_pkg::*;

  cfg_t              cfg;
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              advance;
  logic              out_valid;
  result_t           out_item;
  result_t           parse_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte      <= SYNC_BYTE_RESET;
      cfg.min_frame_type <= MIN_TYPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_BYTE: cfg.sync_byte      <= cfg_data;
        REG_MIN_TYPE:  cfg.min_frame_type <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance       = stage_valid && (!out_valid || result.ready);
  assign byte_in.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (byte_in.ready) begin
      stage_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      stage_byte <= byte_in.payload.rx_byte;
    end
  end

  frx_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .rx_byte (stage_byte),
    .result  (parse_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= parse_result;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_item;

endmodule

`default_nettype wire
